// ===== sv/glmd_pkg.sv =====
// Shared types and constants for the grid local maximum detector.
package glmd_pkg;

   localparam int PIXEL_W     = 16;
   localparam int NUM_ROWS_W  = 11;
   localparam int NUM_COLS_W  = 7;
   localparam int CSR_DATA_W  = 11;
   localparam int PEAK_ROW_W  = 10;
   localparam int PEAK_COL_W  = 6;
   localparam int HIT_W       = 3;

   // line store word: upper-ok flag above the pixel value
   localparam int LINE_W      = PIXEL_W + 1;

   typedef enum logic [0:0] {
      CSR_NUM_ROWS = 1'b0,
      CSR_NUM_COLS = 1'b1
   } csr_index_type;

   // bit positions in a hit mask, in result order
   localparam int HIT_ABOVE = 0;
   localparam int HIT_LEFT  = 1;
   localparam int HIT_SELF  = 2;

   typedef struct packed {
      logic [HIT_W-1:0]      hits;
      logic [PEAK_ROW_W-1:0] row;
      logic [PEAK_COL_W-1:0] col;
   } peak_group_type;

endpackage

// ===== sv/grid_local_maximum_detector.sv =====
// Peak words of an accepted pixel are registered in the result queue before the result port.
// Throughput: one pixel per cycle while each pixel yields at most one peak and the
// result port is ready; a pixel with several peaks holds the result port until all its words
// are taken, and a two-group queue lets input run ahead by one group. The line store needs no clearing pass.
// Reset: grid size 1x1, position row 0 column 0, result queue empty.
module grid_local_maximum_detector
   import glmd_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [PIXEL_W-1:0] req_pixel_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PEAK_ROW_W-1:0] rsp_peak_row,
   output logic [PEAK_COL_W-1:0] rsp_peak_col,
   output logic                  rsp_last
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);

   function automatic logic [COL_W-1:0] cols_last_of(input logic [NUM_COLS_W-1:0] w);
      int n;
      n = int'(w);
      if (n == 0) n = 1;
      if (n > MAX_COLS) n = MAX_COLS;
      return COL_W'(n - 1);
   endfunction

   function automatic logic [ROW_W-1:0] rows_last_of(input logic [NUM_ROWS_W-1:0] w);
      int n;
      n = int'(w);
      if (n == 0) n = 1;
      if (n > MAX_ROWS) n = MAX_ROWS;
      return ROW_W'(n - 1);
   endfunction

   logic [ROW_W-1:0] rows_last_ff, rows_last_in;
   logic [COL_W-1:0] cols_last_ff, cols_last_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic signed [PIXEL_W-1:0] upl_ff, upl_in;
   logic signed [PIXEL_W-1:0] cur1_ff, cur1_in;
   logic                      cur1_ok_ff, cur1_ok_in;
   logic signed [PIXEL_W-1:0] cur2_ff, cur2_in;

   logic                      accept;
   logic                      restart;
   logic [ROW_W-1:0]          r;
   logic [COL_W-1:0]          c;
   logic                      last_row;
   logic                      last_col;
   logic [LINE_W-1:0]         up_word_a;
   logic [LINE_W-1:0]         up_word_b;
   logic signed [PIXEL_W-1:0] up_mid;
   logic signed [PIXEL_W-1:0] up_right;
   logic signed [PIXEL_W-1:0] v;
   logic                      cur_ok;
   logic [COL_W-1:0]          rd_addr_a;
   logic [COL_W-1:0]          rd_addr_b;
   logic [HIT_W-1:0]          hits;
   peak_group_type            group;
   logic                      push_ready;

   assign csr_ready = 1'b1;
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign v         = req_pixel_value;

   assign restart  = (row_ff > rows_last_ff) || (col_ff > cols_last_ff);
   assign r        = restart ? '0 : row_ff;
   assign c        = restart ? '0 : col_ff;
   assign last_row = (r == rows_last_ff);
   assign last_col = (c == cols_last_ff);

   assign up_mid   = $signed(up_word_a[PIXEL_W-1:0]);
   assign up_right = $signed(up_word_b[PIXEL_W-1:0]);
   assign cur_ok   = (r == '0) || (v >= up_mid);

   assign rd_addr_a = last_col ? '0 : c + 1'b1;
   assign rd_addr_b = rd_addr_a + 1'b1;

   always_comb begin
      hits = '0;
      hits[HIT_ABOVE] = (r != '0) && up_word_a[PIXEL_W] && (up_mid >= v)
                        && !(c != '0 && up_mid < upl_ff)
                        && !(c < cols_last_ff && up_mid < up_right);
      hits[HIT_LEFT]  = last_row && (c != '0) && cur1_ok_ff && (cur1_ff >= v)
                        && !(c > COL_W'(1) && cur1_ff < cur2_ff);
      hits[HIT_SELF]  = last_row && last_col && cur_ok
                        && !(c != '0 && v < cur1_ff);
      group.hits = hits;
      group.row  = PEAK_ROW_W'(r);
      group.col  = PEAK_COL_W'(c);
   end

   always_comb begin
      rows_last_in = rows_last_ff;
      cols_last_in = cols_last_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_ROWS: rows_last_in = rows_last_of(csr_wdata[NUM_ROWS_W-1:0]);
            CSR_NUM_COLS: cols_last_in = cols_last_of(csr_wdata[NUM_COLS_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      upl_in     = upl_ff;
      cur1_in    = cur1_ff;
      cur1_ok_in = cur1_ok_ff;
      cur2_in    = cur2_ff;
      if (accept) begin
         upl_in     = up_mid;
         cur1_in    = v;
         cur1_ok_in = cur_ok;
         cur2_in    = cur1_ff;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : r + 1'b1;
         end else begin
            col_in = c + 1'b1;
            row_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff <= '0;
         cols_last_ff <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         rows_last_ff <= rows_last_in;
         cols_last_ff <= cols_last_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      upl_ff     <= upl_in;
      cur1_ff    <= cur1_in;
      cur1_ok_ff <= cur1_ok_in;
      cur2_ff    <= cur2_in;
   end

   glmd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_COLS)
   ) u_line (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (c),
      .wr_data   ({cur_ok, v}),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (up_word_a),
      .rd_data_b (up_word_b)
   );

   glmd_rsp_queue u_rsp (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (accept && hits != '0),
      .push_group   (group),
      .push_ready   (push_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_peak_row (rsp_peak_row),
      .rsp_peak_col (rsp_peak_col),
      .rsp_last     (rsp_last)
   );

   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !restart && col_ff != cols_last_ff |=> col_ff == $past(col_ff) + 1'b1)
      else $error("column position did not advance");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last_col && last_row |=> row_ff == '0 && col_ff == '0)
      else $error("grid end did not wrap position");

   a_self_last_cell: assert property (@(posedge clock) disable iff (reset)
      hits[HIT_SELF] |-> last_row && last_col)
      else $error("cell decided itself away from grid end");

endmodule

// ===== sv/glmd_ram.sv =====
// Generic RAM: one write port, two registered read ports, new data on collision.
module glmd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem_ff[rd_addr_a];
         rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem_ff[rd_addr_b];
      end
   end

endmodule

// ===== sv/glmd_rsp_queue.sv =====
// Two-deep queue of peak groups, drained one result word per cycle while rsp_ready is high.
module glmd_rsp_queue
   import glmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  peak_group_type        push_group,
   output logic                  push_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PEAK_ROW_W-1:0] rsp_peak_row,
   output logic [PEAK_COL_W-1:0] rsp_peak_col,
   output logic                  rsp_last
);

   peak_group_type   front_ff, front_in;
   peak_group_type   back_ff, back_in;
   logic [HIT_W-1:0] front_hits_left;
   logic             push;

   assign push_ready = (back_ff.hits == '0);
   assign push       = push_valid && push_ready;
   assign rsp_valid  = (front_ff.hits != '0);
   assign rsp_last   = ((front_ff.hits & (front_ff.hits - 1'b1)) == '0);

   always_comb begin
      rsp_peak_row = front_ff.row;
      rsp_peak_col = front_ff.col;
      if (front_ff.hits[HIT_ABOVE]) begin
         rsp_peak_row = front_ff.row - 1'b1;
      end else if (front_ff.hits[HIT_LEFT]) begin
         rsp_peak_col = front_ff.col - 1'b1;
      end
   end

   always_comb begin
      front_hits_left = front_ff.hits;
      if (rsp_valid && rsp_ready) begin
         front_hits_left = front_ff.hits & (front_ff.hits - 1'b1);
      end
      front_in      = front_ff;
      front_in.hits = front_hits_left;
      back_in       = back_ff;
      if (front_hits_left == '0) begin
         if (back_ff.hits != '0) begin
            front_in     = back_ff;
            back_in.hits = '0;
         end else if (push) begin
            front_in = push_group;
         end
      end else if (push) begin
         back_in = push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.hits <= '0;
         back_ff.hits  <= '0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
      end
   end

   a_back_needs_front: assert property (@(posedge clock) disable iff (reset)
      back_ff.hits != '0 |-> front_ff.hits != '0)
      else $error("queue back entry held while front is empty");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("group ended before its last word");

endmodule

// ===== tb/grid_local_maximum_detector_tb.sv =====
// Testbench for grid_local_maximum_detector: raster pixel stimulus, predicted peak words, checks.
`timescale 1ns / 100ps

module grid_local_maximum_detector_tb;
   import glmd_pkg::*;

   localparam int MAX_COLS      = 64;
   localparam int MAX_ROWS      = 1024;
   localparam int RANDOM_PIXELS = 48;
   localparam int TALL_PIXELS   = 16;
   localparam int CYCLE_LIMIT   = 500000;

   typedef enum int {
      FILL_WIDE,
      FILL_NARROW,
      FILL_EXTREME
   } fill_kind_type;

   typedef struct packed {
      logic [PEAK_ROW_W-1:0] row;
      logic [PEAK_COL_W-1:0] col;
      logic                  last;
   } peak_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   csr_index_type               csr_index = CSR_NUM_ROWS;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [PIXEL_W-1:0]   req_pixel_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [PEAK_ROW_W-1:0]       rsp_peak_row;
   logic [PEAK_COL_W-1:0]       rsp_peak_col;
   logic                        rsp_last;

   logic signed [PIXEL_W-1:0]   pixel_queue [$];
   peak_word_type               pending_peaks [$];

   // mirror of the detector state
   logic [NUM_ROWS_W-1:0]       cfg_rows;
   logic [NUM_COLS_W-1:0]       cfg_cols;
   logic signed [PIXEL_W-1:0]   above_row [MAX_COLS];
   logic signed [PIXEL_W-1:0]   this_row [MAX_COLS];
   bit                          above_ok [MAX_COLS];
   bit                          this_ok [MAX_COLS];
   int unsigned                 at_row;
   int unsigned                 at_col;

   int                          error_count = 0;
   int                          pixels_accepted = 0;
   int                          peaks_checked = 0;
   int                          csr_writes = 0;
   int                          cycle_count = 0;
   int                          send_wait = 0;
   int                          recv_wait = 0;
   bit                          send_bursting = 1'b0;
   bit                          recv_bursting = 1'b0;

   grid_local_maximum_detector #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_peak_row    (rsp_peak_row),
      .rsp_peak_col    (rsp_peak_col),
      .rsp_last        (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic void find_peaks(input logic signed [PIXEL_W-1:0] v);
      int unsigned               rows;
      int unsigned               cols;
      int unsigned               r;
      int unsigned               c;
      logic signed [PIXEL_W-1:0] x;
      bit                        ok;
      bit                        bottom;
      peak_word_type             found [$];
      rows = (cfg_rows == 0) ? 1 : ((cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows);
      cols = (cfg_cols == 0) ? 1 : ((cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols);
      if (at_row >= rows || at_col >= cols) begin
         at_row = 0;
         at_col = 0;
      end
      r = at_row;
      c = at_col;
      bottom = (r == rows - 1);
      if (r > 0) begin
         x = above_row[c];
         ok = above_ok[c] && x >= v;
         if (c > 0 && x < above_row[c - 1]) ok = 1'b0;
         if (c + 1 < cols && x < above_row[c + 1]) ok = 1'b0;
         if (ok) found.push_back('{PEAK_ROW_W'(r - 1), PEAK_COL_W'(c), 1'b0});
      end
      if (bottom && c > 0) begin
         x = this_row[c - 1];
         ok = this_ok[c - 1] && x >= v;
         if (c > 1 && x < this_row[c - 2]) ok = 1'b0;
         if (ok) found.push_back('{PEAK_ROW_W'(r), PEAK_COL_W'(c - 1), 1'b0});
      end
      this_row[c] = v;
      this_ok[c] = (r == 0) || v >= above_row[c];
      if (bottom && c == cols - 1) begin
         ok = this_ok[c];
         if (c > 0 && v < this_row[c - 1]) ok = 1'b0;
         if (ok) found.push_back('{PEAK_ROW_W'(r), PEAK_COL_W'(c), 1'b0});
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) pending_peaks.push_back(found[i]);
      at_col = c + 1;
      if (at_col >= cols) begin
         at_col = 0;
         above_row = this_row;
         above_ok = this_ok;
         at_row = r + 1;
         if (at_row >= rows) at_row = 0;
      end
   endfunction

   function automatic logic signed [PIXEL_W-1:0] draw_pixel(input fill_kind_type fill);
      case (fill)
         FILL_NARROW: return PIXEL_W'(int'($urandom_range(0, 3)) - 2);
         FILL_EXTREME: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   // hold until every pixel is taken and every peak word is back
   task automatic settle();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || pending_peaks.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type which, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_grid(input int unsigned rows, input int unsigned cols);
      logic [CSR_DATA_W-1:0] rows_word;
      logic [CSR_DATA_W-1:0] cols_word;
      rows_word = CSR_DATA_W'(rows);
      if (rows == 1 && $urandom_range(0, 3) == 0) rows_word = '0;
      if (rows == MAX_ROWS && $urandom_range(0, 1) == 1)
         rows_word = CSR_DATA_W'($urandom_range(MAX_ROWS + 1, (1 << CSR_DATA_W) - 1));
      cols_word = CSR_DATA_W'(cols);
      cols_word[CSR_DATA_W-1:NUM_COLS_W] = (CSR_DATA_W - NUM_COLS_W)'($urandom_range(0, 15));
      if (cols == 1 && $urandom_range(0, 3) == 0) cols_word[NUM_COLS_W-1:0] = '0;
      if (cols == MAX_COLS && $urandom_range(0, 1) == 1)
         cols_word[NUM_COLS_W-1:0] =
            NUM_COLS_W'($urandom_range(MAX_COLS + 1, (1 << NUM_COLS_W) - 1));
      settle();
      write_csr(CSR_NUM_ROWS, rows_word);
      write_csr(CSR_NUM_COLS, cols_word);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (!req_valid || req_ready) begin
         if (send_wait > 0 || pixel_queue.size() == 0) begin
            if (send_wait > 0) send_wait--;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_pixel_value <= pixel_queue.pop_front();
            if ($urandom_range(0, 31) == 0) send_bursting = !send_bursting;
            send_wait = send_bursting ? 0 : $urandom_range(0, 16);
         end
      end
   end

   always @(posedge clock) begin
      peak_word_type want;
      if (reset) begin
         cfg_rows = NUM_ROWS_W'(1);
         cfg_cols = NUM_COLS_W'(1);
         at_row = 0;
         at_col = 0;
         foreach (above_row[i]) begin
            above_row[i] = '0;
            this_row[i] = '0;
            above_ok[i] = 1'b0;
            this_ok[i] = 1'b0;
         end
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_ROWS) cfg_rows = csr_wdata[NUM_ROWS_W-1:0];
            else cfg_cols = csr_wdata[NUM_COLS_W-1:0];
            csr_writes++;
         end
         if (req_valid && req_ready) begin
            find_peaks(req_pixel_value);
            pixels_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_peaks.size() == 0) begin
               $error("unexpected peak word: row %0d col %0d last %0d",
                      rsp_peak_row, rsp_peak_col, rsp_last);
               error_count++;
            end else begin
               want = pending_peaks.pop_front();
               if (rsp_peak_row !== want.row) begin
                  $error("peak_row: expected %0d, got %0d", want.row, rsp_peak_row);
                  error_count++;
               end
               if (rsp_peak_col !== want.col) begin
                  $error("peak_col: expected %0d, got %0d", want.col, rsp_peak_col);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  error_count++;
               end
            end
            peaks_checked++;
            if ($urandom_range(0, 31) == 0) recv_bursting = !recv_bursting;
            recv_wait = recv_bursting ? 0 : $urandom_range(0, 16);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("grid_local_maximum_detector_tb: errors");
         $finish;
      end
   end

   initial begin
      int unsigned   rows;
      int unsigned   cols;
      int unsigned   total;
      int unsigned   cut;
      int unsigned   rows_cap;
      int unsigned   cols_cap;
      int            random_pixels;
      fill_kind_type fill;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 1x1 grid out of reset: every pixel is a peak
      pixel_queue.push_back(16'sh7fff);
      pixel_queue.push_back(16'sh8000);
      settle();
      write_csr(CSR_NUM_ROWS, '0);
      write_csr(CSR_NUM_COLS, '0);
      pixel_queue.push_back(16'sh0000);

      // flat 2x2: all cells tie, last pixel yields three words
      set_grid(2, 2);
      repeat (4) pixel_queue.push_back(16'sh8000);

      // single row with extremes
      set_grid(1, 5);
      pixel_queue.push_back(-16'sd1);
      pixel_queue.push_back(16'sd5);
      pixel_queue.push_back(16'sh8000);
      pixel_queue.push_back(16'sh7fff);
      pixel_queue.push_back(16'sd7);

      // shrink the grid under a partial one: column then row restart
      set_grid(4, 3);
      repeat (4) pixel_queue.push_back(draw_pixel(FILL_WIDE));
      settle();
      write_csr(CSR_NUM_COLS, CSR_DATA_W'(1));
      repeat (2) pixel_queue.push_back(draw_pixel(FILL_WIDE));
      settle();
      write_csr(CSR_NUM_ROWS, CSR_DATA_W'(2));
      repeat (2) pixel_queue.push_back(draw_pixel(FILL_WIDE));

      // narrow the grid at a row boundary: lines from the wider row stay in use
      set_grid(3, 4);
      repeat (4) pixel_queue.push_back(draw_pixel(FILL_NARROW));
      settle();
      write_csr(CSR_NUM_COLS, CSR_DATA_W'(2));
      repeat (4) pixel_queue.push_back(draw_pixel(FILL_NARROW));

      // tallest grid, rows saturated, one column, cut short by the next size
      settle();
      write_csr(CSR_NUM_ROWS, '1);
      write_csr(CSR_NUM_COLS, '0);
      repeat (TALL_PIXELS) pixel_queue.push_back(draw_pixel(FILL_NARROW));

      // widest grid, columns saturated
      settle();
      write_csr(CSR_NUM_COLS, CSR_DATA_W'((1 << NUM_COLS_W) - 1));
      write_csr(CSR_NUM_ROWS, CSR_DATA_W'(2));
      repeat (2 * MAX_COLS)
         pixel_queue.push_back(draw_pixel(fill_kind_type'($urandom_range(0, 2))));

      // random grids, some cut short and followed by a size that forces a restart
      rows_cap = 0;
      cols_cap = 0;
      random_pixels = 0;
      settle();
      while (random_pixels < RANDOM_PIXELS) begin
         if ($urandom_range(0, 7) == 0) begin
            rows = 1;
            cols = $urandom_range(10, MAX_COLS);
         end else begin
            rows = $urandom_range(1, 6);
            cols = $urandom_range(1, 9);
         end
         if (rows_cap != 0) rows = $urandom_range(1, rows_cap);
         if (cols_cap != 0) cols = $urandom_range(1, cols_cap);
         rows_cap = 0;
         cols_cap = 0;
         total = rows * cols;
         fill = fill_kind_type'($urandom_range(0, 2));
         if (total > 1 && $urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, total - 1);
            if (cut % cols != 0) cols_cap = cut % cols;
            else rows_cap = cut / cols;
            total = cut;
         end
         set_grid(rows, cols);
         repeat (total) pixel_queue.push_back(draw_pixel(fill));
         random_pixels += total;
      end

      settle();
      $display("Run covered %0d pixels, %0d peak words and %0d register writes,",
               pixels_accepted, peaks_checked, csr_writes);
      $display("over grids from 1x1 to 64 columns, saturated sizes, ties, cuts and restarts.");
      if (error_count == 0) begin
         $display("grid_local_maximum_detector_tb: clean");
      end else begin
         $display("grid_local_maximum_detector_tb: errors");
      end
      $finish;
   end

endmodule
